@@ rtl/glyph_to_packed_pixel_words_defines.svh @@
// Assertion macros shared by the glyph blitter RTL.
`ifndef GLYPH_TO_PACKED_PIXEL_WORDS_DEFINES_SVH
`define GLYPH_TO_PACKED_PIXEL_WORDS_DEFINES_SVH
`ifndef ASSERT_OFF
`define G2P_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("g2p assertion failed");
`define G2P_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("g2p forbidden condition seen");
`else
`define G2P_ASSERT(lbl, clk, rst, prop)
`define G2P_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ rtl/g2p_pkg.sv @@
// Shared types and constants of the glyph blitter.
`default_nettype none
package g2p_pkg;

   localparam int G2P_PIXELS_PER_BYTE = 4;
   localparam int G2P_QUEUE_DEPTH     = 2;

   localparam logic [6:0] G2P_STRIDE_RESET = 7'd40;
   localparam logic [6:0] G2P_HEIGHT_RESET = 7'd16;

   typedef enum logic {
      G2P_OP_START = 1'b0,
      G2P_OP_DATA  = 1'b1
   } g2p_op_type;

   typedef enum logic {
      G2P_REG_STRIDE = 1'b0,
      G2P_REG_HEIGHT = 1'b1
   } g2p_reg_type;

   // one finished frame buffer word, address not yet formed
   typedef struct packed {
      logic [31:0] data;
      logic [6:0]  col_word;
      logic [9:0]  row;
      logic        done;
   } g2p_word_type;

   // all words produced by one font byte; mask marks the ones present
   typedef struct packed {
      logic [G2P_PIXELS_PER_BYTE-1:0]               mask;
      g2p_word_type [G2P_PIXELS_PER_BYTE-1:0]       words;
   } g2p_packet_type;

   typedef struct packed {
      logic full;
      logic empty;
   } g2p_qctl_type;

endpackage
`default_nettype wire

@@ rtl/g2p_if.sv @@
// Channel interfaces of the glyph blitter: request, response and register write.
`default_nettype none
interface g2p_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [9:0] origin_x;
   logic [8:0] origin_y;
   logic [6:0] glyph_width;
   logic [7:0] font_byte;

   modport source (output valid, op, origin_x, origin_y, glyph_width, font_byte,
                   input ready);
   modport sink   (input valid, op, origin_x, origin_y, glyph_width, font_byte,
                   output ready);
endinterface

interface g2p_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] word_address;
   logic [31:0] word_data;
   logic        last;
   logic        glyph_done;

   modport source (output valid, word_address, word_data, last, glyph_done,
                   input ready);
   modport sink   (input valid, word_address, word_data, last, glyph_done,
                   output ready);
endinterface

interface g2p_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [6:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/g2p_front.sv @@
// Front end: takes request items, tracks glyph position and builds word packets.
`default_nettype none
module g2p_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   g2p_req_if.sink                    req_ch,
   input  wire logic [6:0]            glyph_height,
   input  wire g2p_pkg::g2p_qctl_type q_ctl,
   output logic                       push,
   output g2p_pkg::g2p_packet_type    packet
);
   import g2p_pkg::*;

   logic [9:0]  base_column_ff;
   logic [8:0]  base_row_ff;
   logic [6:0]  active_width_ff;
   logic [6:0]  pixel_column_ff, pixel_column_in;
   logic [6:0]  pixel_row_ff, pixel_row_in;
   logic [31:0] accum_ff, accum_in;
   logic        active_ff, active_in;
   logic        accept;

   assign req_ch.ready = !q_ctl.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // walk the four pixels of the byte; each may close a word
   always_comb begin
      logic [6:0]  pc;
      logic [6:0]  pr;
      logic [31:0] acc;
      logic        act;
      logic [1:0]  pix;
      logic [10:0] col;
      logic        row_end;
      logic        word_end;
      pc       = pixel_column_ff;
      pr       = pixel_row_ff;
      acc      = accum_ff;
      act      = active_ff;
      pix      = '0;
      col      = '0;
      row_end  = 1'b0;
      word_end = 1'b0;
      packet   = '0;
      for (int p = 0; p < G2P_PIXELS_PER_BYTE; p++) begin
         if (act) begin
            pix      = req_ch.font_byte[2*(G2P_PIXELS_PER_BYTE-1-p) +: 2];
            col      = {1'b0, base_column_ff} + {4'd0, pc};
            acc      = acc | ({30'd0, pix} << {~col[3:0], 1'b0});
            pc       = pc + 7'd1;
            row_end  = (pc >= active_width_ff);
            word_end = (col[3:0] == 4'hF);
            if (row_end || word_end) begin
               packet.mask[p]           = 1'b1;
               packet.words[p].data     = acc;
               packet.words[p].col_word = col[10:4];
               packet.words[p].row      = {1'b0, base_row_ff} + {3'd0, pr};
               packet.words[p].done     = 1'b0;
               if (row_end) begin
                  pc = '0;
                  pr = pr + 7'd1;
                  if (pr >= glyph_height) begin
                     packet.words[p].done = 1'b1;
                     act                  = 1'b0;
                  end
               end
               acc = '0;
            end
         end
      end
      pixel_column_in = pc;
      pixel_row_in    = pr;
      accum_in        = acc;
      active_in       = act;
   end

   assign push = accept && (req_ch.op == G2P_OP_DATA) && (packet.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         base_column_ff  <= '0;
         base_row_ff     <= '0;
         active_width_ff <= '0;
         pixel_column_ff <= '0;
         pixel_row_ff    <= '0;
         accum_ff        <= '0;
      end else if (accept) begin
         unique case (g2p_op_type'(req_ch.op))
            G2P_OP_START: begin
               base_column_ff  <= req_ch.origin_x;
               base_row_ff     <= req_ch.origin_y;
               active_width_ff <= req_ch.glyph_width;
               pixel_column_ff <= '0;
               pixel_row_ff    <= '0;
               accum_ff        <= '0;
               active_ff       <= (req_ch.glyph_width != '0) && (glyph_height != '0);
            end
            G2P_OP_DATA: begin
               pixel_column_ff <= pixel_column_in;
               pixel_row_ff    <= pixel_row_in;
               accum_ff        <= accum_in;
               active_ff       <= active_in;
            end
            default: begin
               active_ff <= active_ff;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/g2p_queue.sv @@
// Short packet queue between the front and back ends.
`default_nettype none
`include "glyph_to_packed_pixel_words_defines.svh"
module g2p_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire g2p_pkg::g2p_packet_type push_packet,
   input  wire logic                    pop,
   output g2p_pkg::g2p_packet_type      head,
   output g2p_pkg::g2p_qctl_type        ctl
);
   import g2p_pkg::*;

   localparam int PtrW = (G2P_QUEUE_DEPTH > 1) ? $clog2(G2P_QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(G2P_QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(G2P_QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(G2P_QUEUE_DEPTH);

   g2p_packet_type entries_ff [G2P_QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign ctl.full  = (count_ff == FullCnt);
   assign ctl.empty = (count_ff == '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_packet;
      end
   end

   `G2P_NEVER(a_queue_no_overflow, clock, reset, push && ctl.full)
   `G2P_NEVER(a_queue_no_underflow, clock, reset, pop && ctl.empty)

endmodule
`default_nettype wire

@@ rtl/g2p_back.sv @@
// Back end: unpacks queued packets word by word, forms addresses, drives responses.
`default_nettype none
`include "glyph_to_packed_pixel_words_defines.svh"
module g2p_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire g2p_pkg::g2p_packet_type head,
   input  wire g2p_pkg::g2p_qctl_type   q_ctl,
   input  wire logic [6:0]              row_stride,
   output logic                         pop,
   g2p_rsp_if.source                    rsp_ch
);
   import g2p_pkg::*;

   localparam int SelW = $clog2(G2P_PIXELS_PER_BYTE);

   logic [G2P_PIXELS_PER_BYTE-1:0] issued_ff, issued_in;
   logic [G2P_PIXELS_PER_BYTE-1:0] remaining;
   logic [G2P_PIXELS_PER_BYTE-1:0] sel_bit;
   logic [SelW-1:0]                sel;
   logic                           sel_last;
   logic                           issue;

   // multiply stage
   logic        a_valid_ff;
   logic [14:0] a_prod_ff;
   logic [6:0]  a_colw_ff;
   logic [31:0] a_data_ff;
   logic        a_last_ff;
   logic        a_done_ff;

   // output register
   logic        o_valid_ff;
   logic [14:0] o_addr_ff;
   logic [31:0] o_data_ff;
   logic        o_last_ff;
   logic        o_done_ff;

   logic o_ready;
   logic a_ready;
   logic a_move;

   assign o_ready = !o_valid_ff || rsp_ch.ready;
   assign a_ready = !a_valid_ff || o_ready;
   assign a_move  = a_valid_ff && o_ready;

   assign remaining = head.mask & ~issued_ff;

   // lowest remaining word goes first
   always_comb begin
      sel = '0;
      for (int i = G2P_PIXELS_PER_BYTE - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            sel = SelW'(i);
         end
      end
      sel_bit  = G2P_PIXELS_PER_BYTE'(1) << sel;
      sel_last = ((remaining & ~sel_bit) == '0);
   end

   assign issue = !q_ctl.empty && a_ready;
   assign pop   = issue && sel_last;

   always_comb begin
      issued_in = issued_ff;
      if (issue) begin
         issued_in = sel_last ? '0 : (issued_ff | sel_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff  <= '0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         issued_ff <= issued_in;
         if (a_ready) begin
            a_valid_ff <= issue;
         end
         if (o_ready) begin
            o_valid_ff <= a_valid_ff;
         end
      end
   end

   // the address wraps at 15 bits, so only the low product bits are kept
   always_ff @(posedge clock) begin
      if (issue) begin
         a_prod_ff <= 15'({7'd0, head.words[sel].row} * {10'd0, row_stride});
         a_colw_ff <= head.words[sel].col_word;
         a_data_ff <= head.words[sel].data;
         a_last_ff <= sel_last;
         a_done_ff <= head.words[sel].done;
      end
      if (a_move) begin
         o_addr_ff <= a_prod_ff + {8'd0, a_colw_ff};
         o_data_ff <= a_data_ff;
         o_last_ff <= a_last_ff;
         o_done_ff <= a_done_ff;
      end
   end

   assign rsp_ch.valid        = o_valid_ff;
   assign rsp_ch.word_address = o_addr_ff;
   assign rsp_ch.word_data    = o_data_ff;
   assign rsp_ch.last         = o_last_ff;
   assign rsp_ch.glyph_done   = o_done_ff;

   `G2P_ASSERT(a_issued_within_mask, clock, reset, !q_ctl.empty |-> ((issued_ff & ~head.mask) == '0))
   `G2P_ASSERT(a_issued_clear_when_empty, clock, reset, q_ctl.empty |-> (issued_ff == '0))

endmodule
`default_nettype wire

@@ rtl/glyph_to_packed_pixel_words.sv @@
// Top level of the 2bpp glyph blitter: registers, front end, queue and back end.
//
// Usage: send a start item (op 0) carrying origin and glyph width on req_ch, then
// the glyph's font bytes (op 1), four pixels each, rows running on. Each finished
// frame buffer word leaves on rsp_ch with its word address; last marks the final
// word caused by one byte, glyph_done the word that closes the glyph's last row.
// Registers row_stride_words (index 0) and glyph_height (index 1) are written on
// csr_ch, which is always ready.
// The first word of a byte passes the packet queue, the multiply stage and the
// output register before it is valid on rsp_ch. Throughput: one byte per cycle
// while bytes close at most one word and rsp_ch does not stall; a byte closing
// more words holds the back end until each has issued, one word per cycle.
// Reset clears the glyph state and the queue and restores stride 40, height 16.
// When the receiver stalls, the output and multiply registers hold, the two-entry
// packet queue fills, and then req_ch.ready drops.
`default_nettype none
module glyph_to_packed_pixel_words (
   input  wire logic clock,
   input  wire logic reset,
   g2p_req_if.sink   req_ch,
   g2p_rsp_if.source rsp_ch,
   g2p_csr_if.sink   csr_ch
);
   import g2p_pkg::*;

   logic [6:0]     row_stride_ff;
   logic [6:0]     glyph_height_ff;
   logic           push;
   logic           pop;
   g2p_packet_type push_packet;
   g2p_packet_type head;
   g2p_qctl_type   q_ctl;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff   <= G2P_STRIDE_RESET;
         glyph_height_ff <= G2P_HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         unique case (g2p_reg_type'(csr_ch.index))
            G2P_REG_STRIDE: row_stride_ff   <= csr_ch.data;
            G2P_REG_HEIGHT: glyph_height_ff <= csr_ch.data;
            default: begin
               row_stride_ff <= row_stride_ff;
            end
         endcase
      end
   end

   g2p_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .glyph_height (glyph_height_ff),
      .q_ctl        (q_ctl),
      .push         (push),
      .packet       (push_packet)
   );

   g2p_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_packet (push_packet),
      .pop         (pop),
      .head        (head),
      .ctl         (q_ctl)
   );

   g2p_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_ctl      (q_ctl),
      .row_stride (row_stride_ff),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Testbench of the 2bpp glyph blitter: directed and random glyphs checked word by word.
module testbench;
   import g2p_pkg::*;

   typedef struct {
      logic [14:0] addr;
      logic [31:0] data;
      logic        last;
      logic        done;
   } fb_word_type;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   g2p_req_if req_ch ();
   g2p_rsp_if rsp_ch ();
   g2p_csr_if csr_ch ();

   glyph_to_packed_pixel_words DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // blitter model: registers and glyph state
   logic [6:0]  stride_q = G2P_STRIDE_RESET;
   logic [6:0]  height_q = G2P_HEIGHT_RESET;
   logic [9:0]  org_col  = '0;
   logic [8:0]  org_row  = '0;
   logic [6:0]  span     = '0;
   logic [6:0]  col_pos  = '0;
   logic [6:0]  row_pos  = '0;
   logic [31:0] accum    = '0;
   logic        drawing  = 1'b0;

   fb_word_type pending_words[$];

   int send_idle_pct = 27;
   int recv_idle_pct = 74;
   int error_count   = 0;
   int words_checked = 0;
   int glyphs_closed = 0;
   int items_sent    = 0;
   int items_drawn   = 0;
   int reg_writes    = 0;
   int stall_cycles  = 0;

   task automatic latch_glyph(input logic [9:0] x, input logic [8:0] y, input logic [6:0] w);
      org_col = x;
      org_row = y;
      span    = w;
      col_pos = '0;
      row_pos = '0;
      accum   = '0;
      drawing = (w != 0) && (height_q != 0);
   endtask

   task automatic blit_font_byte(input logic [7:0] fb);
      fb_word_type burst[$];
      fb_word_type w;
      int       col, slot, addr;
      logic     row_end, word_end;
      for (int p = 0; p < G2P_PIXELS_PER_BYTE; p++) begin
         if (!drawing) break;
         col   = org_col + col_pos;
         slot  = 15 - col % 16;
         accum = accum | (32'(fb[7 - 2 * p -: 2]) << (2 * slot));
         col_pos  = col_pos + 7'd1;
         row_end  = (col_pos >= span);
         word_end = (col % 16 == 15);
         if (row_end || word_end) begin
            addr   = col / 16 + (org_row + row_pos) * stride_q;
            w.addr = addr[14:0];
            w.data = accum;
            w.last = 1'b0;
            w.done = 1'b0;
            if (row_end) begin
               col_pos = '0;
               row_pos = row_pos + 7'd1;
               // height is read live, so a lowered register closes the glyph here
               if (row_pos >= height_q) begin
                  w.done  = 1'b1;
                  drawing = 1'b0;
               end
            end
            burst.push_back(w);
            accum = '0;
         end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_words.push_back(burst[i]);
   endtask

   task automatic send_item(input g2p_op_type op, input logic [9:0] x, input logic [8:0] y,
                            input logic [6:0] w, input logic [7:0] fb);
      logic was_drawing;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.origin_x    <= x;
      req_ch.origin_y    <= y;
      req_ch.glyph_width <= w;
      req_ch.font_byte   <= fb;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      was_drawing = drawing;
      if (op == G2P_OP_START) begin
         latch_glyph(x, y, w);
         if (drawing) items_drawn++;
      end else begin
         blit_font_byte(fb);
         if (was_drawing) items_drawn++;
      end
   endtask

   task automatic start_glyph(input int x, input int y, input int w);
      send_item(G2P_OP_START, 10'(x), 9'(y), 7'(w), 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] fb);
      send_item(G2P_OP_DATA, 10'($urandom), 9'($urandom), 7'($urandom), fb);
   endtask

   // a start or a dropped byte makes no word, so allow for work still in flight
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input g2p_reg_type idx, input logic [6:0] value);
      wait_for_drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == G2P_REG_STRIDE) stride_q = value;
      else height_q = value;
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic set_config(input int stride, input int height);
      write_register(G2P_REG_STRIDE, 7'(stride));
      write_register(G2P_REG_HEIGHT, 7'(height));
   endtask

   task automatic test_idle_and_empty_glyphs();
      send_byte(8'hFF);
      start_glyph(0, 0, 0);
      send_byte(8'hFF);
      write_register(G2P_REG_HEIGHT, 7'd0);
      start_glyph(16, 8, 8);
      send_byte(8'h55);
   endtask

   // origin at the far corner: words close at the 16-pixel boundary and at row ends, and the address wraps
   task automatic test_screen_edge();
      set_config(127, 2);
      start_glyph(1023, 511, 3);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'h3C);
   endtask

   task automatic test_narrow_glyph();
      set_config(1, 4);
      start_glyph(7, 100, 1);
      send_byte(8'hE4);
   endtask

   task automatic test_restart_mid_glyph();
      start_glyph(0, 3, 16);
      send_byte(8'h1B);
      send_byte(8'hC6);
      start_glyph(30, 4, 4);
      send_byte(8'h9F);
   endtask

   task automatic test_height_lowered();
      set_config(40, 8);
      start_glyph(6, 20, 4);
      send_byte(8'hFF);
      send_byte(8'h81);
      write_register(G2P_REG_HEIGHT, 7'd1);
      send_byte(8'h7E);
      send_byte(8'hFF);
   endtask

   task automatic test_random_glyphs(input int stride, input int height, input int target);
      int first, w, max_w, nbytes, shape;
      set_config(stride, height);
      first = items_drawn;
      while (items_drawn - first < target) begin
         shape = $urandom_range(0, 99);
         max_w = 160 / height;
         if (max_w > 127) max_w = 127;
         if (max_w < 1) max_w = 1;
         if ($urandom_range(0, 9) == 0) w = max_w;
         else w = $urandom_range(1, (max_w < 16) ? max_w : 16);
         if (shape < 8) begin
            send_byte(8'($urandom));
         end else if (shape < 14) begin
            start_glyph($urandom_range(0, 1023), $urandom_range(0, 511), 0);
            send_byte(8'($urandom));
         end else begin
            nbytes = (w * height + 3) / 4;
            if (shape < 24) nbytes = $urandom_range(0, nbytes - 1);
            else if (shape < 44) nbytes = nbytes + $urandom_range(1, 2);
            start_glyph($urandom_range(0, 1023), $urandom_range(0, 511), w);
            repeat (nbytes) send_byte(8'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   always @(posedge clock) begin : check_words
      fb_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: address %h data %h", rsp_ch.word_address,
                   rsp_ch.word_data);
            error_count++;
         end else begin
            exp_w = pending_words.pop_front();
            words_checked++;
            if (exp_w.done) glyphs_closed++;
            if (rsp_ch.word_address !== exp_w.addr) begin
               $error("word_address: expected %h, got %h", exp_w.addr, rsp_ch.word_address);
               error_count++;
            end
            if (rsp_ch.word_data !== exp_w.data) begin
               $error("word_data: expected %h, got %h", exp_w.data, rsp_ch.word_data);
               error_count++;
            end
            if (rsp_ch.last !== exp_w.last) begin
               $error("last: expected %b, got %b", exp_w.last, rsp_ch.last);
               error_count++;
            end
            if (rsp_ch.glyph_done !== exp_w.done) begin
               $error("glyph_done: expected %b, got %b", exp_w.done, rsp_ch.glyph_done);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.op          <= G2P_OP_START;
      req_ch.origin_x    <= '0;
      req_ch.origin_y    <= '0;
      req_ch.glyph_width <= '0;
      req_ch.font_byte   <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= G2P_REG_STRIDE;
      csr_ch.data        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_empty_glyphs();
      test_screen_edge();
      test_narrow_glyph();
      test_restart_mid_glyph();
      test_height_lowered();

      test_random_glyphs(1, 1, 16);
      test_random_glyphs(127, 4, 16);
      send_idle_pct = 74;
      recv_idle_pct = 27;
      test_random_glyphs(0, 2, 16);
      test_random_glyphs(40, 16, 16);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_glyphs(64, 127, 16);
      test_random_glyphs(93, 7, 16);
      wait_for_drain();

      $display("Sent %0d items (%0d drawn), %0d register writes, three idle mixes.",
               items_sent, items_drawn, reg_writes);
      $display("Compared %0d frame buffer words, %0d of them closing a glyph.",
               words_checked, glyphs_closed);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
